// ----- sv/lambda_term_lexer_macros.svh -----
// Assertion macros shared by the lexer's checking code.
`ifndef LAMBDA_TERM_LEXER_MACROS_SVH
`define LAMBDA_TERM_LEXER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define LTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ltl_pkg.sv -----
// Shared types and constants of the lambda term lexer.
package ltl_pkg;

  localparam int MAX_LINE_DEF    = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] SPACE_MAX  = 8'h20;
  localparam logic [7:0] CASE_MASK  = 8'hDF;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  typedef enum logic [3:0] {
    TK_INVALID = 4'd0,
    TK_EOF     = 4'd1,
    TK_BSLASH  = 4'd2,
    TK_DOT     = 4'd3,
    TK_COLONEQ = 4'd4,
    TK_OPEN    = 4'd5,
    TK_CLOSE   = 4'd6,
    TK_IDENT   = 4'd7,
    TK_LET     = 4'd8
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [9:0]  start;
    logic [10:0] length;
  } token_t;

  // One queue entry: the tokens caused by one input beat.
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Letters of the keyword, by position.
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h6C;
      2'd1:    c = 8'h65;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/lambda_term_lexer.sv -----
// Top level of the lambda term lexer: front end, token queue and back end.
// The lexer accepts one byte beat (or end-of-line beat) every cycle while the
// queue is not full; the byte is classified and the lexer state updated in the
// cycle it is taken. A beat yields zero, one or two tokens; two-token beats
// (identifier flush followed by a punctuation token, an invalid token or EOF)
// leave the output one token at a time, and the QUEUE_DEPTH-entry queue absorbs
// bursts of two-token beats and output stalls; input is held off only while the
// queue is full. A taken beat's entry is first written into the queue, and the
// back end then loads its first token into the output register. Lines longer
// than MAX_LINE bytes give an invalid token.
`include "lambda_term_lexer_macros.svh"

module lambda_term_lexer import ltl_pkg::*; #(
  parameter int MAX_LINE    = MAX_LINE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_code,
  output logic [9:0]  token_start,
  output logic [10:0] token_length,
  output logic        last_in_run
);

  logic        accept, push, pop;
  entry_t      push_entry, head;
  queue_stat_t stat;
  token_t      out_tok;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  ltl_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_byte  (char_byte),
    .end_of_line(end_of_line),
    .push       (push),
    .push_entry (push_entry)
  );

  ltl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  ltl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok),
    .out_last (last_in_run)
  );

  assign token_code   = out_tok.kind;
  assign token_start  = out_tok.start;
  assign token_length = out_tok.length;

  // an idle output with a queued entry must pick it up next cycle
  `LTL_ASSERT_NEXT(a_drain, !stat.empty && !out_valid, out_valid, "queued entry not taken")
  `LTL_ASSERT_NOW(a_plain_tok,
    out_valid && token_code != TK_IDENT && token_code != TK_LET,
    token_start == 10'd0 && token_length == 11'd0, "non-identifier token carries extent")
  `LTL_ASSERT_NOW(a_eof_last, out_valid && token_code == TK_EOF, last_in_run,
    "EOF not last of its beat")
  `LTL_ASSERT_NOW(a_no_lost_push, push, !stat.full, "entry pushed into full queue")

endmodule

// ----- sv/ltl_front.sv -----
// Front end: takes byte beats, tracks lexer state and builds token entries.
module ltl_front import ltl_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       end_of_line,
  output logic       push,
  output entry_t     push_entry
);

  localparam int POS_W   = $clog2(MAX_LINE + 1);
  localparam int START_W = $clog2(MAX_LINE);

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_IDENT = 2'd1,
    M_COLON = 2'd2,
    M_STOP  = 2'd3
  } mode_t;

  mode_t              mode, mode_next;
  logic [POS_W-1:0]   line_pos, line_pos_next;
  logic [START_W-1:0] id_start, id_start_next;
  logic [POS_W-1:0]   id_len, id_len_next;
  logic [1:0]         kw_prog, kw_prog_next;
  logic               kw_match, kw_match_next;

  logic [START_W+9:0] start_ext;
  logic [POS_W+10:0]  len_ext;
  token_t             id_tok, tok_a, tok_b, byte_tok;
  logic               has_a, has_b, byte_has, done;
  logic [7:0]         upper;
  logic               is_space, is_letter, is_word;

  assign upper     = char_byte & CASE_MASK;
  assign is_space  = (char_byte != 8'h00) && (char_byte <= SPACE_MAX);
  assign is_letter = (upper >= 8'h41) && (upper <= 8'h5A);
  assign is_word   = is_letter || ((char_byte >= 8'h30) && (char_byte <= 8'h39)) ||
                     (char_byte == CH_UNDER);

  assign start_ext = {10'b0, id_start};
  assign len_ext   = {11'b0, id_len};

  always_comb begin
    id_tok.kind   = (kw_match && kw_prog == 2'd3 && id_len == POS_W'(3)) ? TK_LET : TK_IDENT;
    id_tok.start  = start_ext[9:0];
    id_tok.length = len_ext[10:0];
  end

  always_comb begin
    mode_next     = mode;
    line_pos_next = line_pos;
    id_start_next = id_start;
    id_len_next   = id_len;
    kw_prog_next  = kw_prog;
    kw_match_next = kw_match;
    tok_a         = '{kind: TK_INVALID, start: '0, length: '0};
    tok_b         = '{kind: TK_INVALID, start: '0, length: '0};
    byte_tok      = '{kind: TK_INVALID, start: '0, length: '0};
    has_a         = 1'b0;
    has_b         = 1'b0;
    byte_has      = 1'b0;
    done          = 1'b0;

    if (end_of_line) begin
      unique case (mode)
        M_IDENT: begin
          tok_a      = id_tok;
          has_a      = 1'b1;
          tok_b.kind = TK_EOF;
          has_b      = 1'b1;
        end
        M_COLON: has_a = 1'b1;
        M_IDLE: begin
          tok_a.kind = TK_EOF;
          has_a      = 1'b1;
        end
        default: ;
      endcase
      mode_next     = M_IDLE;
      line_pos_next = '0;
      id_start_next = '0;
      id_len_next   = '0;
      kw_prog_next  = '0;
      kw_match_next = 1'b1;
    end else if (mode != M_STOP) begin
      if (line_pos >= POS_W'(MAX_LINE)) begin
        has_a     = 1'b1;
        mode_next = M_STOP;
      end else begin
        line_pos_next = line_pos + POS_W'(1);
        if (mode == M_COLON) begin
          has_a = 1'b1;
          if (char_byte == CH_EQ) begin
            tok_a.kind = TK_COLONEQ;
            mode_next  = M_IDLE;
          end else begin
            mode_next = M_STOP;
          end
          done = 1'b1;
        end else if (mode == M_IDENT) begin
          if (is_word) begin
            if (kw_prog != 2'd3) begin
              if (char_byte != kw_char(kw_prog)) kw_match_next = 1'b0;
              kw_prog_next = kw_prog + 2'd1;
            end else begin
              kw_match_next = 1'b0;
            end
            id_len_next = id_len + POS_W'(1);
            done        = 1'b1;
          end else begin
            tok_a     = id_tok;
            has_a     = 1'b1;
            mode_next = M_IDLE;
          end
        end

        if (!done) begin
          byte_has = 1'b1;
          priority if (is_space) begin
            byte_has = 1'b0;
          end else if (is_letter) begin
            byte_has      = 1'b0;
            mode_next     = M_IDENT;
            id_start_next = line_pos[START_W-1:0];
            id_len_next   = POS_W'(1);
            kw_prog_next  = 2'd1;
            kw_match_next = (char_byte == kw_char(2'd0));
          end else if (char_byte == CH_BSLASH) begin
            byte_tok.kind = TK_BSLASH;
          end else if (char_byte == CH_DOT) begin
            byte_tok.kind = TK_DOT;
          end else if (char_byte == CH_OPEN) begin
            byte_tok.kind = TK_OPEN;
          end else if (char_byte == CH_CLOSE) begin
            byte_tok.kind = TK_CLOSE;
          end else if (char_byte == CH_COLON) begin
            byte_has  = 1'b0;
            mode_next = M_COLON;
          end else begin
            mode_next = M_STOP;
          end

          // a flushed identifier goes first; the byte's own token follows it
          if (byte_has) begin
            if (has_a) begin
              tok_b = byte_tok;
              has_b = 1'b1;
            end else begin
              tok_a = byte_tok;
              has_a = 1'b1;
            end
          end
        end
      end
    end
  end

  assign push              = accept && has_a;
  assign push_entry.first  = tok_a;
  assign push_entry.second = tok_b;
  assign push_entry.two    = has_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      line_pos <= '0;
      id_start <= '0;
      id_len   <= '0;
      kw_prog  <= '0;
      kw_match <= 1'b1;
    end else if (accept) begin
      mode     <= mode_next;
      line_pos <= line_pos_next;
      id_start <= id_start_next;
      id_len   <= id_len_next;
      kw_prog  <= kw_prog_next;
      kw_match <= kw_match_next;
    end
  end

endmodule

// ----- sv/ltl_queue.sv -----
// Short register queue of token entries between front and back.
module ltl_queue import ltl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      push_entry,
  input  logic        pop,
  output entry_t      head,
  output queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/ltl_back.sv -----
// Back end: splits queue entries into single token beats on the output register.
module ltl_back import ltl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  queue_stat_t stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output token_t      out_tok,
  output logic        out_last
);

  logic   pend;
  token_t pend_tok;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign pop       = slot_free && !pend && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (slot_free) begin
      if (pend) begin
        out_valid <= 1'b1;
        out_tok   <= pend_tok;
        out_last  <= 1'b1;
        pend      <= 1'b0;
      end else if (!stat.empty) begin
        out_valid <= 1'b1;
        out_tok   <= head.first;
        out_last  <= !head.two;
        pend      <= head.two;
        pend_tok  <= head.second;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the lambda term lexer: directed table, random lines, flow control.
`timescale 1ns / 100ps

module tb;
  import ltl_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BEATS = 140;
  localparam int LINE_LIMIT   = 1024;
  localparam int N_ROWS       = 25;
  localparam logic [23:0] KEYWORD = "let";

  typedef enum logic [1:0] {LX_IDLE, LX_IDENT, LX_COLON, LX_STOP} lex_mode_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [9:0]  start;
    logic [10:0] length;
    logic        last;
  } exp_tok_t;

  // Per-beat note: a typed expectation replaces the predicted one.
  typedef struct packed {
    logic     typed;
    exp_tok_t tok;
  } beat_note_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eol;
    logic        typed;
    tok_kind_t   kind;
    logic [9:0]  start;
    logic [10:0] length;
  } lex_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_byte;
  logic        end_of_line;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  token_code;
  logic [9:0]  token_start;
  logic [10:0] token_length;
  logic        last_in_run;

  lambda_term_lexer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_byte    (char_byte),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_code   (token_code),
    .token_start  (token_start),
    .token_length (token_length),
    .last_in_run  (last_in_run)
  );

  // predictor state
  lex_mode_t lex_mode;
  int        line_pos;
  int        id_start;
  int        id_len;
  int        kw_pos;
  bit        kw_ok;

  exp_tok_t   fresh_toks[$];
  exp_tok_t   token_q[$];
  beat_note_t beat_notes[$];
  logic [7:0] line_buf[$];
  lex_row_t   lex_rows [N_ROWS];

  int errors;
  int live_beats;
  int quiet;
  int send_idle;
  int recv_stall;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_space(logic [7:0] b);
    return b >= 8'd1 && b <= SPACE_MAX;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    logic [7:0] u;
    u = b & CASE_MASK;
    return u >= 8'h41 && u <= 8'h5A;
  endfunction

  function automatic bit is_word(logic [7:0] b);
    return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER;
  endfunction

  function void emit(tok_kind_t k, int st, int len);
    exp_tok_t t;
    t.kind   = k;
    t.start  = st[9:0];
    t.length = len[10:0];
    t.last   = 1'b0;
    fresh_toks.push_back(t);
  endfunction

  function void rearm();
    lex_mode = LX_IDLE;
    line_pos = 0;
    id_start = 0;
    id_len   = 0;
    kw_pos   = 0;
    kw_ok    = 1'b1;
  endfunction

  function void grow_ident(logic [7:0] b);
    if (kw_pos < 3) begin
      if (b != KEYWORD[8*(2-kw_pos) +: 8]) kw_ok = 1'b0;
      kw_pos++;
    end else begin
      kw_ok = 1'b0;
    end
    id_len++;
  endfunction

  function void flush_ident();
    if (kw_ok && kw_pos == 3 && id_len == 3) emit(TK_LET, id_start, id_len);
    else emit(TK_IDENT, id_start, id_len);
  endfunction

  // Tokens caused by one input beat land in fresh_toks.
  function void lex_step(logic [7:0] b, logic eol);
    bit done;
    int pos;
    fresh_toks.delete();
    done = 1'b0;
    if (eol) begin
      case (lex_mode)
        LX_IDENT: begin
          flush_ident();
          emit(TK_EOF, 0, 0);
        end
        LX_COLON: emit(TK_INVALID, 0, 0);
        LX_IDLE:  emit(TK_EOF, 0, 0);
        default:  ;
      endcase
      rearm();
    end else if (lex_mode != LX_STOP) begin
      if (line_pos >= LINE_LIMIT) begin
        emit(TK_INVALID, 0, 0);
        lex_mode = LX_STOP;
      end else begin
        pos = line_pos;
        line_pos++;
        if (lex_mode == LX_COLON) begin
          if (b == CH_EQ) begin
            emit(TK_COLONEQ, 0, 0);
            lex_mode = LX_IDLE;
          end else begin
            emit(TK_INVALID, 0, 0);
            lex_mode = LX_STOP;
          end
          done = 1'b1;
        end else if (lex_mode == LX_IDENT) begin
          if (is_word(b)) begin
            grow_ident(b);
            done = 1'b1;
          end else begin
            flush_ident();
            lex_mode = LX_IDLE;
          end
        end
        if (!done) begin
          if (is_space(b)) begin
          end else if (is_letter(b)) begin
            lex_mode = LX_IDENT;
            id_start = pos;
            id_len   = 0;
            kw_pos   = 0;
            kw_ok    = 1'b1;
            grow_ident(b);
          end else if (b == CH_BSLASH) begin
            emit(TK_BSLASH, 0, 0);
          end else if (b == CH_DOT) begin
            emit(TK_DOT, 0, 0);
          end else if (b == CH_OPEN) begin
            emit(TK_OPEN, 0, 0);
          end else if (b == CH_CLOSE) begin
            emit(TK_CLOSE, 0, 0);
          end else if (b == CH_COLON) begin
            lex_mode = LX_COLON;
          end else begin
            emit(TK_INVALID, 0, 0);
            lex_mode = LX_STOP;
          end
        end
      end
    end
    if (fresh_toks.size() > 0) fresh_toks[fresh_toks.size()-1].last = 1'b1;
  endfunction

  // Predict on every accepted input beat, check every accepted token.
  beat_note_t note;
  exp_tok_t   want;
  always @(posedge clk) begin
    if (rst) begin
      rearm();
    end else begin
      if (in_valid && in_ready) begin
        note = beat_notes.pop_front();
        if (lex_mode != LX_STOP || end_of_line) live_beats++;
        lex_step(char_byte, end_of_line);
        if (note.typed) token_q.push_back(note.tok);
        else foreach (fresh_toks[i]) token_q.push_back(fresh_toks[i]);
      end
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          $error("unexpected token: kind %0d start %0d length %0d",
                 token_code, token_start, token_length);
          errors++;
        end else begin
          want = token_q.pop_front();
          if (token_code !== want.kind) begin
            $error("token_code: expected %0d, actual %0d", want.kind, token_code);
            errors++;
          end
          if (token_start !== want.start) begin
            $error("token_start: expected %0d, actual %0d", want.start, token_start);
            errors++;
          end
          if (token_length !== want.length) begin
            $error("token_length: expected %0d, actual %0d", want.length, token_length);
            errors++;
          end
          if (last_in_run !== want.last) begin
            $error("last_in_run: expected %0d, actual %0d", want.last, last_in_run);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog: cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic e, input logic typed,
                           input exp_tok_t tok);
    beat_note_t n;
    n.typed = typed;
    n.tok   = tok;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    beat_notes.push_back(n);
    in_valid    <= 1'b1;
    char_byte   <= b;
    end_of_line <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic play_line();
    foreach (line_buf[i]) send_beat(line_buf[i], 1'b0, 1'b0, '0);
    // byte lane is don't-care on an end-of-line beat
    send_beat(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    line_buf.delete();
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_ident(int len);
    int r;
    line_buf.push_back(8'($urandom_range(25)) + ($urandom_range(1) ? 8'h61 : 8'h41));
    for (int i = 1; i < len; i++) begin
      r = $urandom_range(37);
      if (r < 26) line_buf.push_back(8'(r) + ($urandom_range(1) ? 8'h61 : 8'h41));
      else if (r < 36) line_buf.push_back(8'h30 + 8'(r - 26));
      else line_buf.push_back(CH_UNDER);
    end
  endfunction

  function automatic void add_piece();
    case ($urandom_range(9))
      0, 1: add_ident($urandom_range(1, 10));
      2: begin
        case ($urandom_range(5))
          0, 1: push_text("let");
          2: push_text("Let");
          3: push_text("le");
          4: push_text("lets");
          default: push_text("lex");
        endcase
      end
      3: line_buf.push_back(CH_BSLASH);
      4: line_buf.push_back(CH_DOT);
      5: line_buf.push_back(CH_OPEN);
      6: line_buf.push_back(CH_CLOSE);
      7: push_text(":=");
      default: begin
        repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(1, 32)));
      end
    endcase
  endfunction

  task automatic random_line();
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      // empty line
    end else if (r < 80) begin
      repeat ($urandom_range(1, 8)) add_piece();
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(4))
          0, 1: add_piece();
          2: line_buf.push_back(CH_COLON);
          default: line_buf.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    play_line();
  endtask

  int target;
  int line_no;
  exp_tok_t row_tok;

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    char_byte   = 8'h00;
    end_of_line = 1'b0;
    send_idle   = 0;
    recv_stall  = 0;

    lex_rows = '{
      '{8'h00,    1'b1, 1'b1, TK_EOF,     10'd0, 11'd0},
      '{8'h6C,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'h65,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'h74,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'h20,    1'b0, 1'b1, TK_LET,     10'd0, 11'd3},
      '{CH_BSLASH, 1'b0, 1'b1, TK_BSLASH, 10'd0, 11'd0},
      '{8'h78,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_DOT,   1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_OPEN,  1'b0, 1'b1, TK_OPEN,    10'd0, 11'd0},
      '{8'h5A,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_UNDER, 1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'h39,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_CLOSE, 1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_COLON, 1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_EQ,    1'b0, 1'b1, TK_COLONEQ, 10'd0, 11'd0},
      '{8'h61,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'hFF,    1'b1, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_COLON, 1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'h3D,    1'b1, 1'b1, TK_INVALID, 10'd0, 11'd0},
      '{8'h00,    1'b0, 1'b1, TK_INVALID, 10'd0, 11'd0},
      '{8'hFF,    1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'h00,    1'b1, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{CH_COLON, 1'b0, 1'b0, TK_INVALID, 10'd0, 11'd0},
      '{8'h78,    1'b0, 1'b1, TK_INVALID, 10'd0, 11'd0},
      '{8'h00,    1'b1, 1'b0, TK_INVALID, 10'd0, 11'd0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (lex_rows[i]) begin
      row_tok.kind   = lex_rows[i].kind;
      row_tok.start  = lex_rows[i].start;
      row_tok.length = lex_rows[i].length;
      row_tok.last   = 1'b1;
      send_beat(lex_rows[i].ch, lex_rows[i].eol, lex_rows[i].typed, row_tok);
    end

    // identifier running past the line limit, started near the top offsets
    send_idle  = 37;
    recv_stall = 37;
    while (line_buf.size() < 1012) add_piece();
    line_buf.push_back(8'h20);
    add_ident(1040 - line_buf.size());
    play_line();

    target  = live_beats + RANDOM_BEATS;
    line_no = 0;
    while (live_beats < target) begin
      case ((line_no / 3) % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 48; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 48; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      random_line();
      line_no++;
    end

    in_valid   <= 1'b0;
    recv_stall = 0;
    while (token_q.size() > 0 || beat_notes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
